FILE: hdl/xasp_pkg.sv
// Package for the XOR archive stream parser: payload structs, phase and
// kind codes, controller/datapath interface structs and size constants.
// Used by xasp_ctrl, xasp_datapath and the top level.
package xasp_pkg;

   // record table sizing
   localparam int MAX_RECORDS = 256;
   localparam int TBL_AW      = $clog2(MAX_RECORDS);
   localparam int REC_W       = $clog2(MAX_RECORDS + 1);

   localparam logic [7:0] KEY_RESET = 8'hF7;
   localparam logic [7:0] END_FLAG  = 8'h80;
   localparam logic [7:0] VER_BYTE  = 8'h00;

   // input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0]       plain_byte;
      logic [3:0]       byte_kind;
      logic [REC_W-1:0] record_index;
      logic [63:0]      field_value;
      logic             field_complete;
      logic             last_of_file;
      logic             all_done;
      logic [1:0]       error_code;
   } rsp_type;

   // reported byte kinds
   typedef enum logic [3:0] {
      K_MAGIC   = 4'd0,
      K_VERSION = 4'd1,
      K_FLAG    = 4'd2,
      K_NAMELEN = 4'd3,
      K_NAME    = 4'd4,
      K_SIZE    = 4'd5,
      K_TIME    = 4'd6,
      K_END     = 4'd7,
      K_BODY    = 4'd8,
      K_TRAIL   = 4'd9,
      K_ERROR   = 4'd10
   } kind_type;

   // sticky error codes
   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_MAGIC   = 2'd1,
      ERR_VERSION = 2'd2,
      ERR_FULL    = 2'd3
   } err_type;

   // parse phase, one-hot
   typedef enum logic [9:0] {
      PH_MAGIC   = 10'b00_0000_0001,
      PH_VERSION = 10'b00_0000_0010,
      PH_FLAG    = 10'b00_0000_0100,
      PH_NAMELEN = 10'b00_0000_1000,
      PH_NAME    = 10'b00_0001_0000,
      PH_SIZE    = 10'b00_0010_0000,
      PH_TIME    = 10'b00_0100_0000,
      PH_BODY    = 10'b00_1000_0000,
      PH_TRAIL   = 10'b01_0000_0000,
      PH_ERROR   = 10'b10_0000_0000
   } phase_type;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_SEEK_RD  = 3'b010,
      ST_SEEK_CHK = 3'b100
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic step;
      logic seek_rd;
      logic seek_chk;
      logic key_wr;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic need_seek;
      logic scan_end;
      logic scan_hit;
   } dp_status_type;

   // expected magic byte by position
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'hC0;
         2'd1:    val = 8'h4A;
         2'd2:    val = 8'hC0;
         2'd3:    val = 8'hBA;
         default: val = 8'hC0;
      endcase
      return val;
   endfunction

endpackage

FILE: hdl/xasp_ctrl.sv
// Sequencer for the XOR archive stream parser: input handshake and the
// record table scan that finds the next non-empty record. Uses xasp_pkg.
module xasp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  xasp_pkg::dp_status_type status,
   output xasp_pkg::ctrl_cmd_type  cmd
);

   xasp_pkg::ctrl_state_type state_ff, state_in;

   // take a byte only when idle and the result register is free
   assign req_stall = !((state_ff == xasp_pkg::ST_IDLE) && status.out_free);
   assign csr_ready = 1'b1;

   always_comb begin
      cmd.step     = req_valid && !req_stall;
      cmd.seek_rd  = (state_ff == xasp_pkg::ST_SEEK_RD);
      cmd.seek_chk = (state_ff == xasp_pkg::ST_SEEK_CHK);
      cmd.key_wr   = csr_valid;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xasp_pkg::ST_IDLE: begin
            if (cmd.step && status.need_seek) state_in = xasp_pkg::ST_SEEK_RD;
         end
         xasp_pkg::ST_SEEK_RD: begin
            state_in = status.scan_end ? xasp_pkg::ST_IDLE : xasp_pkg::ST_SEEK_CHK;
         end
         xasp_pkg::ST_SEEK_CHK: begin
            state_in = status.scan_hit ? xasp_pkg::ST_IDLE : xasp_pkg::ST_SEEK_RD;
         end
         default: state_in = xasp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= xasp_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: hdl/xasp_datapath.sv
// Datapath for the XOR archive stream parser: key, parse registers, size
// table memory, scan pointer and result register. Uses xasp_pkg.
module xasp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  xasp_pkg::ctrl_cmd_type  cmd,
   output xasp_pkg::dp_status_type status,
   input  xasp_pkg::req_type       req_data,
   input  logic [7:0]              csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output xasp_pkg::rsp_type       rsp_data
);

   // size table
   logic [31:0] size_mem [xasp_pkg::MAX_RECORDS];
   logic [31:0] rd_data_ff;

   // architectural parse state
   logic [7:0]                    key_ff;
   xasp_pkg::phase_type           phase_ff, phase_in;
   logic [7:0]                    cnt_ff, cnt_in;
   logic [63:0]                   acc_ff, acc_in;
   logic                          hok_ff, hok_in;
   logic [xasp_pkg::REC_W-1:0]    rc_ff, rc_in;
   logic [xasp_pkg::REC_W-1:0]    br_ff, br_in;
   logic [31:0]                   brem_ff, brem_in;
   logic [1:0]                    err_ff, err_in;
   logic [xasp_pkg::REC_W-1:0]    scan_ff, scan_in;
   logic                          rsp_valid_ff;
   xasp_pkg::rsp_type             rsp_ff, step_rsp;

   // effective state after restart
   xasp_pkg::phase_type           c_phase;
   logic [7:0]                    c_cnt;
   logic [63:0]                   c_acc;
   logic                          c_hok;
   logic [xasp_pkg::REC_W-1:0]    c_rc, c_br;
   logic [31:0]                   c_brem;
   logic [1:0]                    c_err;

   // step scratch
   logic [7:0]                    b;
   logic [7:0]                    want;
   logic                          hok_n;
   logic [2:0]                    fidx;
   logic [63:0]                   acc_new;
   logic [7:0]                    cnt_dec;
   logic [31:0]                   brem_dec;
   logic                          wr_en;
   logic                          need_seek;
   logic                          rsp_set;
   logic [xasp_pkg::REC_W-1:0]    seek_from;

   assign b = req_data.in_byte ^ key_ff;

   // restart wipes the parse state for this byte
   always_comb begin
      if (req_data.restart) begin
         c_phase = xasp_pkg::PH_MAGIC;
         c_cnt   = '0;
         c_acc   = '0;
         c_hok   = 1'b1;
         c_rc    = '0;
         c_br    = '0;
         c_brem  = '0;
         c_err   = xasp_pkg::ERR_NONE;
      end else begin
         c_phase = phase_ff;
         c_cnt   = cnt_ff;
         c_acc   = acc_ff;
         c_hok   = hok_ff;
         c_rc    = rc_ff;
         c_br    = br_ff;
         c_brem  = brem_ff;
         c_err   = err_ff;
      end
   end

   // per-byte parse step
   always_comb begin
      phase_in  = c_phase;
      cnt_in    = c_cnt;
      acc_in    = c_acc;
      hok_in    = c_hok;
      rc_in     = c_rc;
      br_in     = c_br;
      brem_in   = c_brem;
      err_in    = c_err;
      need_seek = 1'b0;
      seek_from = '0;
      wr_en     = 1'b0;
      want      = xasp_pkg::VER_BYTE;
      hok_n     = c_hok;
      fidx      = c_cnt[2:0];
      acc_new   = c_acc | ({56'd0, b} << {fidx, 3'b000});
      cnt_dec   = c_cnt - 8'd1;
      brem_dec  = c_brem - 32'd1;

      step_rsp                = '0;
      step_rsp.plain_byte     = b;
      step_rsp.byte_kind      = xasp_pkg::K_ERROR;
      step_rsp.record_index   = c_rc;

      case (c_phase)
         xasp_pkg::PH_MAGIC, xasp_pkg::PH_VERSION: begin
            want = (c_phase == xasp_pkg::PH_MAGIC) ?
                   xasp_pkg::magic_byte(c_cnt[1:0]) : xasp_pkg::VER_BYTE;
            hok_n = c_hok && (b == want);
            step_rsp.byte_kind = (c_phase == xasp_pkg::PH_MAGIC) ?
                                 xasp_pkg::K_MAGIC : xasp_pkg::K_VERSION;
            step_rsp.record_index = '0;
            if (c_cnt[1:0] == 2'd3) begin
               cnt_in = '0;
               hok_in = 1'b1;
               if (!hok_n) begin
                  err_in = (c_phase == xasp_pkg::PH_MAGIC) ?
                           xasp_pkg::ERR_MAGIC : xasp_pkg::ERR_VERSION;
                  phase_in = xasp_pkg::PH_ERROR;
               end else begin
                  phase_in = (c_phase == xasp_pkg::PH_MAGIC) ?
                             xasp_pkg::PH_VERSION : xasp_pkg::PH_FLAG;
               end
            end else begin
               cnt_in = {6'd0, c_cnt[1:0] + 2'd1};
               hok_in = hok_n;
            end
         end
         xasp_pkg::PH_FLAG: begin
            if (b == xasp_pkg::END_FLAG) begin
               step_rsp.byte_kind = xasp_pkg::K_END;
               need_seek = 1'b1;
               seek_from = '0;
            end else begin
               step_rsp.byte_kind = xasp_pkg::K_FLAG;
               if (c_rc >= xasp_pkg::REC_W'(xasp_pkg::MAX_RECORDS)) begin
                  err_in   = xasp_pkg::ERR_FULL;
                  phase_in = xasp_pkg::PH_ERROR;
               end else begin
                  phase_in = xasp_pkg::PH_NAMELEN;
               end
            end
         end
         xasp_pkg::PH_NAMELEN: begin
            step_rsp.byte_kind = xasp_pkg::K_NAMELEN;
            cnt_in   = b;
            acc_in   = '0;
            phase_in = (b == 8'd0) ? xasp_pkg::PH_SIZE : xasp_pkg::PH_NAME;
         end
         xasp_pkg::PH_NAME: begin
            step_rsp.byte_kind = xasp_pkg::K_NAME;
            cnt_in = cnt_dec;
            if (cnt_dec == 8'd0) phase_in = xasp_pkg::PH_SIZE;
         end
         xasp_pkg::PH_SIZE, xasp_pkg::PH_TIME: begin
            step_rsp.byte_kind = (c_phase == xasp_pkg::PH_SIZE) ?
                                 xasp_pkg::K_SIZE : xasp_pkg::K_TIME;
            if (((c_phase == xasp_pkg::PH_SIZE) && (fidx >= 3'd3)) ||
                (fidx == 3'd7)) begin
               step_rsp.field_complete = 1'b1;
               step_rsp.field_value    = acc_new;
               acc_in = '0;
               cnt_in = '0;
               if (c_phase == xasp_pkg::PH_SIZE) begin
                  wr_en    = (c_rc < xasp_pkg::REC_W'(xasp_pkg::MAX_RECORDS));
                  phase_in = xasp_pkg::PH_TIME;
               end else begin
                  rc_in    = c_rc + xasp_pkg::REC_W'(1);
                  phase_in = xasp_pkg::PH_FLAG;
               end
            end else begin
               acc_in = acc_new;
               cnt_in = {5'd0, fidx + 3'd1};
            end
         end
         xasp_pkg::PH_BODY: begin
            step_rsp.byte_kind    = xasp_pkg::K_BODY;
            step_rsp.record_index = c_br;
            brem_in = brem_dec;
            if (brem_dec == 32'd0) begin
               step_rsp.last_of_file = 1'b1;
               need_seek = 1'b1;
               seek_from = c_br + xasp_pkg::REC_W'(1);
            end
         end
         xasp_pkg::PH_TRAIL: begin
            step_rsp.byte_kind = xasp_pkg::K_TRAIL;
            step_rsp.all_done  = 1'b1;
         end
         default: begin
            step_rsp.byte_kind = xasp_pkg::K_ERROR;
            phase_in           = xasp_pkg::PH_ERROR;
         end
      endcase
      step_rsp.error_code = err_in;
   end

   // status to the sequencer
   always_comb begin
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      status.need_seek = need_seek;
      status.scan_end  = (scan_ff >= rc_ff);
      status.scan_hit  = (rd_data_ff != 32'd0);
   end

   // table write on a completed size, registered read during the scan
   always_ff @(posedge clock) begin
      if (cmd.step && wr_en) size_mem[c_rc[xasp_pkg::TBL_AW-1:0]] <= acc_new[31:0];
      if (cmd.seek_rd) rd_data_ff <= size_mem[scan_ff[xasp_pkg::TBL_AW-1:0]];
   end

   // scan pointer
   always_comb begin
      scan_in = scan_ff;
      if (cmd.step)
         scan_in = seek_from;
      else if (cmd.seek_chk && !status.scan_hit)
         scan_in = scan_ff + xasp_pkg::REC_W'(1);
   end

   // parse registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= xasp_pkg::KEY_RESET;
         phase_ff <= xasp_pkg::PH_MAGIC;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         hok_ff   <= 1'b1;
         rc_ff    <= '0;
         br_ff    <= '0;
         brem_ff  <= '0;
         err_ff   <= xasp_pkg::ERR_NONE;
         scan_ff  <= '0;
      end else begin
         scan_ff <= scan_in;
         if (cmd.key_wr) key_ff <= csr_data;
         if (cmd.step) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            acc_ff   <= acc_in;
            hok_ff   <= hok_in;
            rc_ff    <= rc_in;
            br_ff    <= br_in;
            brem_ff  <= brem_in;
            err_ff   <= err_in;
         end else if (cmd.seek_rd && status.scan_end) begin
            // nothing left: trailing bytes from here
            br_ff    <= rc_ff;
            brem_ff  <= '0;
            phase_ff <= xasp_pkg::PH_TRAIL;
         end else if (cmd.seek_chk && status.scan_hit) begin
            br_ff    <= scan_ff;
            brem_ff  <= rd_data_ff;
            phase_ff <= xasp_pkg::PH_BODY;
         end
      end
   end

   // result register; a seek result is held back until the scan ends
   assign rsp_set = (cmd.step && !need_seek) ||
                    (cmd.seek_rd && status.scan_end) ||
                    (cmd.seek_chk && status.scan_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) rsp_ff <= step_rsp;
      else if (cmd.seek_rd && status.scan_end) rsp_ff.all_done <= 1'b1;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/xor_archive_stream_parser_unit.sv
// Top level of the XOR archive stream parser: sequencer plus datapath.
// Each accepted byte gets a registered result; for the end flag and the last body byte of a
// record it is held until the table scan finds a nonzero entry or runs past the end.
// Throughput: 1 byte per cycle while the result register is free; a table scan stalls input.
// Reset (synchronous): key 0xF7, magic phase, no errors, no result pending.
module xor_archive_stream_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  xasp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output xasp_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);

   xasp_pkg::ctrl_cmd_type  cmd;
   xasp_pkg::dp_status_type status;

   // handshake and table scan sequencing
   xasp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decode, parse and size table
   xasp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for xor_archive_stream_parser_unit: directed header and record
// bytes, then random archives, key writes and stray bytes under three idle/stall profiles.
// Depends on xasp_pkg (payload structs, kind and error codes) and the parser top level.
module tb_top;

   localparam logic [7:0]  KEY_AT_RESET = xasp_pkg::KEY_RESET;
   localparam logic [31:0] MAGIC_WORD   = 32'hBAC0_4AC0;
   localparam logic [7:0]  END_MARK     = xasp_pkg::END_FLAG;
   localparam int          ENTRY_LIMIT  = xasp_pkg::MAX_RECORDS;
   localparam int          PHASE_BYTES  = 400;
   localparam int          DIR_ROWS     = 25;

   // ways an archive can be spoiled on purpose
   typedef enum int {
      ARC_CLEAN,
      ARC_BAD_MAGIC,
      ARC_BAD_VERSION,
      ARC_CUT_BODY,
      ARC_OVERFLOW
   } arc_flaw_type;

   // one directed row: plain byte, restart, and a typed-in result where one is given
   typedef struct packed {
      logic [7:0]        plain;
      logic              restart;
      logic              typed;
      xasp_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   xasp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   xasp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_data;

   // predicted decoder state
   logic [7:0]                 xkey;
   xasp_pkg::phase_type        ph;
   logic [7:0]                 pos_count;
   logic [63:0]                field_acc;
   logic                       header_good;
   logic [xasp_pkg::REC_W-1:0] rec_count;
   logic [31:0]                size_mem [ENTRY_LIMIT];
   logic [xasp_pkg::REC_W-1:0] body_rec;
   logic [31:0]                body_left;
   xasp_pkg::err_type          fault_code;

   xasp_pkg::rsp_type decoded_q [$];
   int                mismatch_count = 0;
   int                bytes_sent = 0;
   int                send_idle_pct;
   int                recv_stall_pct;
   dir_row_type       dir_table [DIR_ROWS];

   xor_archive_stream_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void restart_parse();
      ph          = xasp_pkg::PH_MAGIC;
      pos_count   = '0;
      field_acc   = '0;
      header_good = 1'b1;
      rec_count   = '0;
      body_rec    = '0;
      body_left   = '0;
      fault_code  = xasp_pkg::ERR_NONE;
   endfunction

   // next record at or after 'from' with a nonzero size; trailing phase if none
   function automatic bit find_next_body(input int from);
      for (int r = from; r < rec_count; r++) begin
         if (size_mem[r[xasp_pkg::TBL_AW-1:0]] != 32'd0) begin
            body_rec  = xasp_pkg::REC_W'(r);
            body_left = size_mem[r[xasp_pkg::TBL_AW-1:0]];
            ph        = xasp_pkg::PH_BODY;
            return 1'b1;
         end
      end
      body_rec  = rec_count;
      body_left = '0;
      ph        = xasp_pkg::PH_TRAIL;
      return 1'b0;
   endfunction

   // decode one byte and walk the archive format, one result per byte
   function automatic xasp_pkg::rsp_type parse_byte(input xasp_pkg::req_type item);
      xasp_pkg::rsp_type o;
      logic [7:0]        b;
      logic [7:0]        want;
      logic [2:0]        idx;
      o = '0;
      if (item.restart) restart_parse();
      b = item.in_byte ^ xkey;
      o.plain_byte = b;
      o.byte_kind  = xasp_pkg::K_ERROR;
      case (ph)
         xasp_pkg::PH_MAGIC, xasp_pkg::PH_VERSION: begin
            idx = {1'b0, pos_count[1:0]};
            if (ph == xasp_pkg::PH_MAGIC) begin
               want        = MAGIC_WORD[8*idx +: 8];
               o.byte_kind = xasp_pkg::K_MAGIC;
            end else begin
               want        = 8'h00;
               o.byte_kind = xasp_pkg::K_VERSION;
            end
            if (b != want) header_good = 1'b0;
            if (idx == 3'd3) begin
               pos_count = '0;
               if (!header_good) begin
                  if (ph == xasp_pkg::PH_MAGIC) fault_code = xasp_pkg::ERR_MAGIC;
                  else fault_code = xasp_pkg::ERR_VERSION;
                  ph = xasp_pkg::PH_ERROR;
               end else if (ph == xasp_pkg::PH_MAGIC) begin
                  ph = xasp_pkg::PH_VERSION;
               end else begin
                  ph = xasp_pkg::PH_FLAG;
               end
               header_good = 1'b1;
            end else begin
               pos_count = 8'(idx) + 8'd1;
            end
         end
         xasp_pkg::PH_FLAG: begin
            o.record_index = rec_count;
            if (b == END_MARK) begin
               o.byte_kind = xasp_pkg::K_END;
               if (!find_next_body(0)) o.all_done = 1'b1;
            end else begin
               o.byte_kind = xasp_pkg::K_FLAG;
               if (rec_count >= ENTRY_LIMIT) begin
                  fault_code = xasp_pkg::ERR_FULL;
                  ph         = xasp_pkg::PH_ERROR;
               end else begin
                  ph = xasp_pkg::PH_NAMELEN;
               end
            end
         end
         xasp_pkg::PH_NAMELEN: begin
            o.byte_kind    = xasp_pkg::K_NAMELEN;
            o.record_index = rec_count;
            pos_count      = b;
            field_acc      = '0;
            if (b == 8'h00) ph = xasp_pkg::PH_SIZE;
            else ph = xasp_pkg::PH_NAME;
         end
         xasp_pkg::PH_NAME: begin
            o.byte_kind    = xasp_pkg::K_NAME;
            o.record_index = rec_count;
            pos_count      = pos_count - 8'd1;
            if (pos_count == 8'h00) ph = xasp_pkg::PH_SIZE;
         end
         xasp_pkg::PH_SIZE, xasp_pkg::PH_TIME: begin
            idx            = pos_count[2:0];
            o.record_index = rec_count;
            field_acc      = field_acc | (64'(b) << (8 * idx));
            if (ph == xasp_pkg::PH_SIZE) o.byte_kind = xasp_pkg::K_SIZE;
            else o.byte_kind = xasp_pkg::K_TIME;
            // size completes on its 4th byte, timestamp on its 8th
            if ((ph == xasp_pkg::PH_SIZE && idx == 3'd3) || idx == 3'd7) begin
               o.field_complete = 1'b1;
               o.field_value    = field_acc;
               field_acc        = '0;
               pos_count        = '0;
               if (ph == xasp_pkg::PH_SIZE) begin
                  if (rec_count < ENTRY_LIMIT)
                     size_mem[rec_count[xasp_pkg::TBL_AW-1:0]] = o.field_value[31:0];
                  ph = xasp_pkg::PH_TIME;
               end else begin
                  rec_count = rec_count + 1'b1;
                  ph        = xasp_pkg::PH_FLAG;
               end
            end else begin
               pos_count = 8'(idx) + 8'd1;
            end
         end
         xasp_pkg::PH_BODY: begin
            o.byte_kind    = xasp_pkg::K_BODY;
            o.record_index = body_rec;
            body_left      = body_left - 32'd1;
            if (body_left == 32'd0) begin
               o.last_of_file = 1'b1;
               if (!find_next_body(int'(body_rec) + 1)) o.all_done = 1'b1;
            end
         end
         xasp_pkg::PH_TRAIL: begin
            o.byte_kind    = xasp_pkg::K_TRAIL;
            o.record_index = rec_count;
            o.all_done     = 1'b1;
         end
         default: begin
            o.byte_kind    = xasp_pkg::K_ERROR;
            o.record_index = rec_count;
            ph             = xasp_pkg::PH_ERROR;
         end
      endcase
      o.error_code = fault_code;
      return o;
   endfunction

   function automatic dir_row_type drow(input logic [7:0] p, input logic rst,
                                        input logic typed, input xasp_pkg::kind_type k,
                                        input int rec, input logic [63:0] fv,
                                        input logic fc);
      dir_row_type row;
      row.plain   = p;
      row.restart = rst;
      row.typed   = typed;
      row.want    = '{plain_byte: p, byte_kind: k, record_index: xasp_pkg::REC_W'(rec),
                      field_value: fv, field_complete: fc, last_of_file: 1'b0,
                      all_done: 1'b0, error_code: xasp_pkg::ERR_NONE};
      return row;
   endfunction

   function automatic logic [7:0] any_flag();
      logic [7:0] f;
      f = 8'($urandom_range(0, 254));
      if (f >= END_MARK) f = f + 8'd1;
      return f;
   endfunction

   // one byte transfer on the request side; the expectation is queued on acceptance
   task automatic send_byte(input logic [7:0] raw, input logic rst, input logic typed,
                            input xasp_pkg::rsp_type want);
      xasp_pkg::req_type item;
      xasp_pkg::rsp_type pred;
      item = '{in_byte: raw, restart: rst};
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = parse_byte(item);
      decoded_q.push_back(typed ? want : pred);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [7:0] p, input logic rst);
      send_byte(p ^ xkey, rst, 1'b0, '0);
   endtask

   // key write only once every queued result has come back
   task automatic write_key(input logic [7:0] k);
      req_valid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      xkey = k;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // full archive: header, records, end flag, body runs, trailing bytes; a flaw cuts it short
   task automatic send_archive(input int nrec, input int size_max, input int name_max,
                               input int tail, input arc_flaw_type flaw);
      logic [7:0]  p;
      logic [31:0] sz;
      logic [63:0] stamp;
      int          nlen;
      int          bad_pos;
      longint      body_len;
      bad_pos  = $urandom_range(0, 3);
      body_len = 0;
      for (int i = 0; i < 8; i++) begin
         p = (i < 4) ? MAGIC_WORD[8*i +: 8] : 8'h00;
         if ((flaw == ARC_BAD_MAGIC && i == bad_pos) ||
             (flaw == ARC_BAD_VERSION && i == bad_pos + 4))
            p = p ^ 8'($urandom_range(1, 255));
         send_plain(p, i == 0);
      end
      if (flaw == ARC_BAD_MAGIC || flaw == ARC_BAD_VERSION) begin
         repeat (tail) send_plain(8'($urandom), 1'b0);
      end else begin
         for (int r = 0; r < nrec; r++) begin
            send_plain(any_flag(), 1'b0);
            if (name_max > 0 && $urandom_range(0, 59) == 0) nlen = 255;
            else nlen = $urandom_range(0, name_max);
            send_plain(8'(nlen), 1'b0);
            repeat (nlen) send_plain(8'($urandom), 1'b0);
            if (flaw == ARC_CUT_BODY && r == 0) sz = $urandom();
            else if ($urandom_range(0, 9) < 3) sz = 32'd0;
            else sz = $urandom_range(1, size_max);
            body_len += sz;
            for (int i = 0; i < 4; i++) send_plain(sz[8*i +: 8], 1'b0);
            stamp = {$urandom(), $urandom()};
            for (int i = 0; i < 8; i++) send_plain(stamp[8*i +: 8], 1'b0);
         end
         if (flaw == ARC_OVERFLOW) begin
            // one flag past the last record: it overflows the table only if nrec reaches ENTRY_LIMIT
            send_plain(any_flag(), 1'b0);
         end else begin
            send_plain(END_MARK, 1'b0);
            if (flaw == ARC_CUT_BODY && body_len > 12) body_len = $urandom_range(0, 12);
            repeat (body_len) send_plain(8'($urandom), 1'b0);
         end
         repeat (tail) send_plain(8'($urandom), 1'b0);
      end
   endtask

   task automatic compare_result(input xasp_pkg::rsp_type want, input xasp_pkg::rsp_type got);
      if (got.plain_byte !== want.plain_byte) begin
         $error("plain_byte: expected %0h, got %0h", want.plain_byte, got.plain_byte);
         mismatch_count++;
      end
      if (got.byte_kind !== want.byte_kind) begin
         $error("byte_kind: expected %0d, got %0d", want.byte_kind, got.byte_kind);
         mismatch_count++;
      end
      if (got.record_index !== want.record_index) begin
         $error("record_index: expected %0d, got %0d", want.record_index, got.record_index);
         mismatch_count++;
      end
      if (got.field_value !== want.field_value) begin
         $error("field_value: expected %0h, got %0h", want.field_value, got.field_value);
         mismatch_count++;
      end
      if (got.field_complete !== want.field_complete) begin
         $error("field_complete: expected %0b, got %0b", want.field_complete,
                got.field_complete);
         mismatch_count++;
      end
      if (got.last_of_file !== want.last_of_file) begin
         $error("last_of_file: expected %0b, got %0b", want.last_of_file, got.last_of_file);
         mismatch_count++;
      end
      if (got.all_done !== want.all_done) begin
         $error("all_done: expected %0b, got %0b", want.all_done, got.all_done);
         mismatch_count++;
      end
      if (got.error_code !== want.error_code) begin
         $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
         mismatch_count++;
      end
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // result transfers against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $error("result with nothing expected: kind %0d byte %0h",
                   rsp_data.byte_kind, rsp_data.plain_byte);
            mismatch_count++;
         end else begin
            compare_result(decoded_q.pop_front(), rsp_data);
         end
      end
   end

   initial begin
      int base;
      int pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      send_idle_pct  = 35;
      recv_stall_pct = 47;
      xkey           = KEY_AT_RESET;
      restart_parse();

      // reset key; one record with empty name, all-ones size, then into its body
      dir_table = '{
         drow(8'hC0, 1'b1, 1'b1, xasp_pkg::K_MAGIC,   0, 64'd0, 1'b0),
         drow(8'h4A, 1'b0, 1'b1, xasp_pkg::K_MAGIC,   0, 64'd0, 1'b0),
         drow(8'hC0, 1'b0, 1'b1, xasp_pkg::K_MAGIC,   0, 64'd0, 1'b0),
         drow(8'hBA, 1'b0, 1'b1, xasp_pkg::K_MAGIC,   0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b1, xasp_pkg::K_VERSION, 0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b1, xasp_pkg::K_VERSION, 0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b1, xasp_pkg::K_VERSION, 0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b1, xasp_pkg::K_VERSION, 0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b1, xasp_pkg::K_FLAG,    0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b1, xasp_pkg::K_NAMELEN, 0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b1, xasp_pkg::K_SIZE,    0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b1, xasp_pkg::K_SIZE,    0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b1, xasp_pkg::K_SIZE,    0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b1, xasp_pkg::K_SIZE,    0, 64'h0000_0000_FFFF_FFFF, 1'b1),
         drow(8'h01, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'h23, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'h45, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'h67, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'h89, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'hAB, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'hCD, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'd0, 1'b0),
         drow(8'hEF, 1'b0, 1'b1, xasp_pkg::K_TIME,    0, 64'hEFCD_AB89_6745_2301, 1'b1),
         drow(8'h80, 1'b0, 1'b0, xasp_pkg::K_END,     0, 64'd0, 1'b0),
         drow(8'h00, 1'b0, 1'b0, xasp_pkg::K_BODY,    0, 64'd0, 1'b0),
         drow(8'hFF, 1'b0, 1'b0, xasp_pkg::K_BODY,    0, 64'd0, 1'b0)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         send_byte(dir_table[i].plain ^ xkey, dir_table[i].restart, dir_table[i].typed,
                   dir_table[i].want);

      // three idling profiles, each with its own key
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct  = 35;
               recv_stall_pct = 47;
               write_key(8'h00);
            end
            1: begin
               send_idle_pct  = 47;
               recv_stall_pct = 35;
               write_key(8'hFF);
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_key(8'($urandom));
            end
         endcase
         base = bytes_sent;
         while (bytes_sent - base < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               write_key(8'($urandom));
            else if (pick < 70)
               send_archive($urandom_range(0, 4), 6, 5, $urandom_range(0, 3), ARC_CLEAN);
            else if (pick < 78)
               send_archive(0, 0, 0, $urandom_range(1, 3), ARC_BAD_MAGIC);
            else if (pick < 86)
               send_archive(0, 0, 0, $urandom_range(1, 3), ARC_BAD_VERSION);
            else if (pick < 93)
               send_archive($urandom_range(1, 3), 6, 5, 0, ARC_CUT_BODY);
            else
               repeat ($urandom_range(1, 6))
                  send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
         end
      end

      // drain, then allow one full table scan for anything stray
      req_valid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (2 * ENTRY_LIMIT + 16) @(negedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
